@@ sv/afbb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afbb_pkg: shared types, widths and helpers for the affine bounding box
// Q16.16 widths, register indexes, pipeline bundles and the round and
// saturate helpers.
// ----------------------------------------------------------------------------
package afbb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HALF_UNIT = 32768;

    localparam int CFG_W     = 32;                 // Q16.16 coefficient
    localparam int CFG_IDX_W = 3;
    localparam int LEFT_W    = 16;                 // rect_left / rect_top
    localparam int SIZE_W    = 15;                 // rect_width / rect_height
    localparam int COORD_W   = LEFT_W + 1;         // edge plus size
    localparam int PROD_W    = CFG_W + COORD_W;    // coefficient times coordinate
    localparam int CORNER_W  = PROD_W + 2;         // two products plus offset
    localparam int INT_W     = CORNER_W - FRAC_BITS;
    localparam int BOX_W     = INT_W + 1;
    localparam int OUT_POS_W = 32;                 // box_left / box_top
    localparam int OUT_SIZE_W = 31;                // box_width / box_height

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_XX = 3'd0,
        REG_SHEAR_XY = 3'd1,
        REG_SHEAR_YX = 3'd2,
        REG_SCALE_YY = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] scale_xx;
        logic signed [CFG_W-1:0] shear_xy;
        logic signed [CFG_W-1:0] shear_yx;
        logic signed [CFG_W-1:0] scale_yy;
        logic signed [CFG_W-1:0] offset_x;
        logic signed [CFG_W-1:0] offset_y;
        logic                    axis;     // both shear terms zero
    } cfg_t;

    typedef struct packed {
        logic                       axis;
        logic signed [CORNER_W-1:0] cx0;
        logic signed [CORNER_W-1:0] cx1;
        logic signed [CORNER_W-1:0] cx2;
        logic signed [CORNER_W-1:0] cx3;
        logic signed [CORNER_W-1:0] cy0;
        logic signed [CORNER_W-1:0] cy1;
        logic signed [CORNER_W-1:0] cy2;
        logic signed [CORNER_W-1:0] cy3;
    } corner_t;

    // Nearest, ties away from zero: bias by half, or half minus one below zero.
    function automatic logic signed [INT_W-1:0] round_q(
        input logic signed [CORNER_W-1:0] v
    );
        logic [CORNER_W-1:0] s;
        s = v + (v[CORNER_W-1] ? CORNER_W'(HALF_UNIT - 1) : CORNER_W'(HALF_UNIT));
        return s[CORNER_W-1:FRAC_BITS];
    endfunction

    function automatic logic [OUT_POS_W-1:0] sat_s32(
        input logic signed [BOX_W-1:0] v
    );
        logic in_range;
        in_range = (&v[BOX_W-1:OUT_POS_W-1]) | ~(|v[BOX_W-1:OUT_POS_W-1]);
        if (in_range)
            return v[OUT_POS_W-1:0];
        else if (v[BOX_W-1])
            return {1'b1, {(OUT_POS_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_POS_W-1){1'b1}}};
    endfunction

    function automatic logic [OUT_SIZE_W-1:0] sat_u31(
        input logic signed [BOX_W-1:0] v
    );
        if (v[BOX_W-1])
            return '0;
        else if (|v[BOX_W-2:OUT_SIZE_W])
            return {OUT_SIZE_W{1'b1}};
        else
            return v[OUT_SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/affine_rect_bounding_box_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// affine_rect_bounding_box_top: bounding box of an affinely mapped rectangle
// Maps the four corners of an integer rectangle through a Q16.16 affine
// matrix and returns the rounded, saturated bounding rectangle.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                                  dir
//  --------  -----------------  ---------------------------------------  ---
//  command   start, busy        rect_left, rect_top, rect_width,         in
//                               rect_height
//  result    done (one cycle)   box_left, box_top, box_width,            out
//                               box_height
//  config    cfg_we             cfg_index, cfg_data                      in
//
//  One beat is taken every cycle: busy never rises, and a beat enters the
//  pipeline on any edge with start high.
//  The pipe has three stages to form the corners (edges, products, sums) and
//  five to finish (pair min/max, final min/max, round, size, saturate). The
//  longest step is one 32 x 17 multiply.
//  Reset clears the pipe valid bits and loads the identity matrix.
//  The receiver cannot stall, so results advance unconditionally; write
//  the matrix only while no beat is in flight.
//
module affine_rect_bounding_box_top
    import afbb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // command beat
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [LEFT_W-1:0] rect_left,
    input  wire logic signed [LEFT_W-1:0] rect_top,
    input  wire logic [SIZE_W-1:0]        rect_width,
    input  wire logic [SIZE_W-1:0]        rect_height,
    // result beat
    output logic                          done,
    output logic signed [OUT_POS_W-1:0]   box_left,
    output logic signed [OUT_POS_W-1:0]   box_top,
    output logic [OUT_SIZE_W-1:0]         box_width,
    output logic [OUT_SIZE_W-1:0]         box_height,
    // matrix registers
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    cfg_t    cfg;
    logic    accept;
    logic    corner_valid;
    corner_t corner;

    // Fully pipelined: hold busy low so every start is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    afbb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Form the four mapped corners in Q35.16.
    afbb_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .cfg         (cfg),
        .out_valid   (corner_valid),
        .corner      (corner)
    );

    // Reduce to extremes, round, and saturate into the result beat.
    afbb_extent u_extent (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (corner_valid),
        .corner     (corner),
        .done       (done),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height)
    );

endmodule
`default_nettype wire

@@ sv/afbb_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afbb_cfg_regs: affine coefficient register file
// Six Q16.16 registers written by index; flags the shear-free case.
// ----------------------------------------------------------------------------
module afbb_cfg_regs
    import afbb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    logic signed [CFG_W-1:0] scale_xx_reg, shear_xy_reg, shear_yx_reg;
    logic signed [CFG_W-1:0] scale_yy_reg, offset_x_reg, offset_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_xx_reg <= CFG_W'(1 << FRAC_BITS);
            shear_xy_reg <= '0;
            shear_yx_reg <= '0;
            scale_yy_reg <= CFG_W'(1 << FRAC_BITS);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE_XX: scale_xx_reg <= cfg_data;
                REG_SHEAR_XY: shear_xy_reg <= cfg_data;
                REG_SHEAR_YX: shear_yx_reg <= cfg_data;
                REG_SCALE_YY: scale_yy_reg <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                default: ;  // drop writes past the last register
            endcase
        end
    end

    always_comb
    begin
        cfg.scale_xx = scale_xx_reg;
        cfg.shear_xy = shear_xy_reg;
        cfg.shear_yx = shear_yx_reg;
        cfg.scale_yy = scale_yy_reg;
        cfg.offset_x = offset_x_reg;
        cfg.offset_y = offset_y_reg;
        cfg.axis     = (shear_xy_reg == '0) && (shear_yx_reg == '0);
    end

endmodule
`default_nettype wire

@@ sv/afbb_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afbb_map: corner mapping pipeline
// Three stages: edges, eight coefficient products, corner sums.
// ----------------------------------------------------------------------------
module afbb_map
    import afbb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic signed [LEFT_W-1:0] rect_left,
    input  wire logic signed [LEFT_W-1:0] rect_top,
    input  wire logic [SIZE_W-1:0]        rect_width,
    input  wire logic [SIZE_W-1:0]        rect_height,
    input  wire cfg_t                     cfg,
    output logic                          out_valid,
    output corner_t                       corner
);

    // stage 1: edges
    logic                      v1_reg, v1_next;
    logic                      axis1_reg, axis1_next;
    logic signed [COORD_W-1:0] l1_reg, r1_reg, t1_reg, b1_reg;
    logic signed [COORD_W-1:0] l1_next, r1_next, t1_next, b1_next;

    // stage 2: products
    logic                     v2_reg, v2_next;
    logic                     axis2_reg, axis2_next;
    logic signed [PROD_W-1:0] xl2_reg, xr2_reg, xt2_reg, xb2_reg;
    logic signed [PROD_W-1:0] yl2_reg, yr2_reg, yt2_reg, yb2_reg;
    logic signed [PROD_W-1:0] xl2_next, xr2_next, xt2_next, xb2_next;
    logic signed [PROD_W-1:0] yl2_next, yr2_next, yt2_next, yb2_next;

    // stage 3: corners
    logic    v3_reg, v3_next;
    corner_t c3_reg, c3_next;

    logic signed [CORNER_W-1:0] ox, oy;

    always_comb
    begin
        v1_next    = in_valid;
        axis1_next = cfg.axis;
        l1_next    = COORD_W'(rect_left);
        t1_next    = COORD_W'(rect_top);
        r1_next    = COORD_W'(rect_left) + $signed(COORD_W'(rect_width));
        b1_next    = COORD_W'(rect_top) + $signed(COORD_W'(rect_height));
    end

    always_comb
    begin
        v2_next    = v1_reg;
        axis2_next = axis1_reg;
        xl2_next   = PROD_W'(cfg.scale_xx) * PROD_W'(l1_reg);
        xr2_next   = PROD_W'(cfg.scale_xx) * PROD_W'(r1_reg);
        xt2_next   = PROD_W'(cfg.shear_yx) * PROD_W'(t1_reg);
        xb2_next   = PROD_W'(cfg.shear_yx) * PROD_W'(b1_reg);
        yl2_next   = PROD_W'(cfg.shear_xy) * PROD_W'(l1_reg);
        yr2_next   = PROD_W'(cfg.shear_xy) * PROD_W'(r1_reg);
        yt2_next   = PROD_W'(cfg.scale_yy) * PROD_W'(t1_reg);
        yb2_next   = PROD_W'(cfg.scale_yy) * PROD_W'(b1_reg);
    end

    // Corner order: (l,t), (r,t), (r,b), (l,b).
    always_comb
    begin
        ox           = CORNER_W'(cfg.offset_x);
        oy           = CORNER_W'(cfg.offset_y);
        v3_next      = v2_reg;
        c3_next.axis = axis2_reg;
        c3_next.cx0  = CORNER_W'(xl2_reg) + CORNER_W'(xt2_reg) + ox;
        c3_next.cx1  = CORNER_W'(xr2_reg) + CORNER_W'(xt2_reg) + ox;
        c3_next.cx2  = CORNER_W'(xr2_reg) + CORNER_W'(xb2_reg) + ox;
        c3_next.cx3  = CORNER_W'(xl2_reg) + CORNER_W'(xb2_reg) + ox;
        c3_next.cy0  = CORNER_W'(yl2_reg) + CORNER_W'(yt2_reg) + oy;
        c3_next.cy1  = CORNER_W'(yr2_reg) + CORNER_W'(yt2_reg) + oy;
        c3_next.cy2  = CORNER_W'(yr2_reg) + CORNER_W'(yb2_reg) + oy;
        c3_next.cy3  = CORNER_W'(yl2_reg) + CORNER_W'(yb2_reg) + oy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis1_reg <= axis1_next;
        l1_reg    <= l1_next;
        r1_reg    <= r1_next;
        t1_reg    <= t1_next;
        b1_reg    <= b1_next;
        axis2_reg <= axis2_next;
        xl2_reg   <= xl2_next;
        xr2_reg   <= xr2_next;
        xt2_reg   <= xt2_next;
        xb2_reg   <= xb2_next;
        yl2_reg   <= yl2_next;
        yr2_reg   <= yr2_next;
        yt2_reg   <= yt2_next;
        yb2_reg   <= yb2_next;
        c3_reg    <= c3_next;
    end

    assign out_valid = v3_reg;
    assign corner    = c3_reg;

endmodule
`default_nettype wire

@@ sv/afbb_extent.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afbb_extent: extent, rounding and saturation pipeline
// Five stages: pair min/max, final min/max, round, size, saturate.
// ----------------------------------------------------------------------------
module afbb_extent
    import afbb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire corner_t          corner,
    output logic                  done,
    output logic [OUT_POS_W-1:0]  box_left,
    output logic [OUT_POS_W-1:0]  box_top,
    output logic [OUT_SIZE_W-1:0] box_width,
    output logic [OUT_SIZE_W-1:0] box_height
);

    // stage 1: pairwise extremes, plus origin and size for the shear-free path
    logic v1_reg, v1_next, axis1_reg, axis1_next;
    logic signed [CORNER_W-1:0] mnx01_reg, mxx01_reg, mnx23_reg, mxx23_reg;
    logic signed [CORNER_W-1:0] mny01_reg, mxy01_reg, mny23_reg, mxy23_reg;
    logic signed [CORNER_W-1:0] orx_reg, ory_reg, szx_reg, szy_reg;
    logic signed [CORNER_W-1:0] mnx01_next, mxx01_next, mnx23_next, mxx23_next;
    logic signed [CORNER_W-1:0] mny01_next, mxy01_next, mny23_next, mxy23_next;
    logic signed [CORNER_W-1:0] orx_next, ory_next, szx_next, szy_next;

    // stage 2: lo/hi per axis (min/max, or origin/size)
    logic v2_reg, v2_next, axis2_reg, axis2_next;
    logic signed [CORNER_W-1:0] lox_reg, hix_reg, loy_reg, hiy_reg;
    logic signed [CORNER_W-1:0] lox_next, hix_next, loy_next, hiy_next;
    logic signed [CORNER_W-1:0] mnx, mxx, mny, mxy;

    // stage 3: rounded
    logic v3_reg, v3_next, axis3_reg, axis3_next;
    logic signed [INT_W-1:0] rlox_reg, rhix_reg, rloy_reg, rhiy_reg;
    logic signed [INT_W-1:0] rlox_next, rhix_next, rloy_next, rhiy_next;

    // stage 4: origin and size
    logic v4_reg, v4_next;
    logic signed [BOX_W-1:0] bx_reg, by_reg, bw_reg, bh_reg;
    logic signed [BOX_W-1:0] bx_next, by_next, bw_next, bh_next;

    // stage 5: saturated outputs
    logic                  v5_reg, v5_next;
    logic [OUT_POS_W-1:0]  left_reg, top_reg, left_next, top_next;
    logic [OUT_SIZE_W-1:0] wid_reg, hgt_reg, wid_next, hgt_next;

    always_comb
    begin
        v1_next    = in_valid;
        axis1_next = corner.axis;
        mnx01_next = (corner.cx1 < corner.cx0) ? corner.cx1 : corner.cx0;
        mxx01_next = (corner.cx1 > corner.cx0) ? corner.cx1 : corner.cx0;
        mnx23_next = (corner.cx3 < corner.cx2) ? corner.cx3 : corner.cx2;
        mxx23_next = (corner.cx3 > corner.cx2) ? corner.cx3 : corner.cx2;
        mny01_next = (corner.cy1 < corner.cy0) ? corner.cy1 : corner.cy0;
        mxy01_next = (corner.cy1 > corner.cy0) ? corner.cy1 : corner.cy0;
        mny23_next = (corner.cy3 < corner.cy2) ? corner.cy3 : corner.cy2;
        mxy23_next = (corner.cy3 > corner.cy2) ? corner.cy3 : corner.cy2;
        // without shear, cx0 is the scaled left plus offset and cx1 - cx0 the
        // scaled width; likewise for y with cy3
        orx_next   = corner.cx0;
        ory_next   = corner.cy0;
        szx_next   = corner.cx1 - corner.cx0;
        szy_next   = corner.cy3 - corner.cy0;
    end

    always_comb
    begin
        mnx        = (mnx23_reg < mnx01_reg) ? mnx23_reg : mnx01_reg;
        mxx        = (mxx23_reg > mxx01_reg) ? mxx23_reg : mxx01_reg;
        mny        = (mny23_reg < mny01_reg) ? mny23_reg : mny01_reg;
        mxy        = (mxy23_reg > mxy01_reg) ? mxy23_reg : mxy01_reg;
        v2_next    = v1_reg;
        axis2_next = axis1_reg;
        lox_next   = axis1_reg ? orx_reg : mnx;
        hix_next   = axis1_reg ? szx_reg : mxx;
        loy_next   = axis1_reg ? ory_reg : mny;
        hiy_next   = axis1_reg ? szy_reg : mxy;
    end

    always_comb
    begin
        v3_next    = v2_reg;
        axis3_next = axis2_reg;
        rlox_next  = round_q(lox_reg);
        rhix_next  = round_q(hix_reg);
        rloy_next  = round_q(loy_reg);
        rhiy_next  = round_q(hiy_reg);
    end

    // Shear-free: a negative size flips and moves the origin back by it.
    always_comb
    begin
        v4_next = v3_reg;
        if (axis3_reg)
        begin
            bx_next = rhix_reg[INT_W-1] ? BOX_W'(rlox_reg) + BOX_W'(rhix_reg)
                                        : BOX_W'(rlox_reg);
            bw_next = rhix_reg[INT_W-1] ? -BOX_W'(rhix_reg) : BOX_W'(rhix_reg);
            by_next = rhiy_reg[INT_W-1] ? BOX_W'(rloy_reg) + BOX_W'(rhiy_reg)
                                        : BOX_W'(rloy_reg);
            bh_next = rhiy_reg[INT_W-1] ? -BOX_W'(rhiy_reg) : BOX_W'(rhiy_reg);
        end
        else
        begin
            bx_next = BOX_W'(rlox_reg);
            bw_next = BOX_W'(rhix_reg) - BOX_W'(rlox_reg);
            by_next = BOX_W'(rloy_reg);
            bh_next = BOX_W'(rhiy_reg) - BOX_W'(rloy_reg);
        end
    end

    always_comb
    begin
        v5_next   = v4_reg;
        left_next = sat_s32(bx_reg);
        top_next  = sat_s32(by_reg);
        wid_next  = sat_u31(bw_reg);
        hgt_next  = sat_u31(bh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis1_reg <= axis1_next;
        mnx01_reg <= mnx01_next;
        mxx01_reg <= mxx01_next;
        mnx23_reg <= mnx23_next;
        mxx23_reg <= mxx23_next;
        mny01_reg <= mny01_next;
        mxy01_reg <= mxy01_next;
        mny23_reg <= mny23_next;
        mxy23_reg <= mxy23_next;
        orx_reg   <= orx_next;
        ory_reg   <= ory_next;
        szx_reg   <= szx_next;
        szy_reg   <= szy_next;
        axis2_reg <= axis2_next;
        lox_reg   <= lox_next;
        hix_reg   <= hix_next;
        loy_reg   <= loy_next;
        hiy_reg   <= hiy_next;
        axis3_reg <= axis3_next;
        rlox_reg  <= rlox_next;
        rhix_reg  <= rhix_next;
        rloy_reg  <= rloy_next;
        rhiy_reg  <= rhiy_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        bw_reg    <= bw_next;
        bh_reg    <= bh_next;
        left_reg  <= left_next;
        top_reg   <= top_next;
        wid_reg   <= wid_next;
        hgt_reg   <= hgt_next;
    end

    assign done       = v5_reg;
    assign box_left   = left_reg;
    assign box_top    = top_reg;
    assign box_width  = wid_reg;
    assign box_height = hgt_reg;

endmodule
`default_nettype wire

@@ tb/sv/affine_rect_bounding_box_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_rect_bounding_box_top_tb: self-checking bench for the affine box
// Drives integer rectangles through the block under a series of Q16.16
// matrices and compares every box against a behavioral predictor. The
// directed tests cover edge values, sign flips, rounding ties and
// saturation. The random tests sweep matrices and rectangles with random
// sender idling.
// ----------------------------------------------------------------------------
module affine_rect_bounding_box_top_tb;

    import afbb_pkg::*;

    localparam int     CLK_PERIOD  = 10;
    localparam int     RESET_CYCLES = 6;
    localparam int     TIMEOUT_NS  = 2_000_000;
    localparam int     TAIL_CYCLES = 16;          // watch window for stray results after the drain
    localparam int     MAX_PRINTS  = 20;
    localparam longint POS_MAX     = 2147483647;
    localparam longint POS_MIN     = -POS_MAX - 1;

    // Indexes past the last matrix register: the block must drop these writes.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [CFG_W-1:0] scale_xx;
        logic signed [CFG_W-1:0] shear_xy;
        logic signed [CFG_W-1:0] shear_yx;
        logic signed [CFG_W-1:0] scale_yy;
        logic signed [CFG_W-1:0] offset_x;
        logic signed [CFG_W-1:0] offset_y;
    } matrix_t;

    typedef struct packed {
        logic signed [LEFT_W-1:0] left;
        logic signed [LEFT_W-1:0] top;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
    } rect_t;

    typedef struct packed {
        logic signed [OUT_POS_W-1:0] left;
        logic signed [OUT_POS_W-1:0] top;
        logic [OUT_SIZE_W-1:0]       width;
        logic [OUT_SIZE_W-1:0]       height;
    } box_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [LEFT_W-1:0]     rect_left = '0;
    logic signed [LEFT_W-1:0]     rect_top = '0;
    logic [SIZE_W-1:0]            rect_width = '0;
    logic [SIZE_W-1:0]            rect_height = '0;
    logic                         done;
    logic signed [OUT_POS_W-1:0]  box_left;
    logic signed [OUT_POS_W-1:0]  box_top;
    logic [OUT_SIZE_W-1:0]        box_width;
    logic [OUT_SIZE_W-1:0]        box_height;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]             cfg_data = '0;

    // ------------------------------------------------------------------------
    // Bench state: shadow copy of the matrix, boxes still owed, counters
    // ------------------------------------------------------------------------
    matrix_t cur_matrix;
    box_t    pending_boxes[$];
    box_t    want_box;
    bit      gaps_on = 1'b1;
    int      errors = 0;
    int      rects_sent = 0;
    int      axis_rects = 0;
    int      sheared_rects = 0;
    int      boxes_checked = 0;
    int      matrix_loads = 0;

    affine_rect_bounding_box_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .done        (done),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d boxes still pending", pending_boxes.size());
        $display("affine_rect_bounding_box_top_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Q16.16 to integer, nearest, ties away from zero.
    function automatic longint round_nearest(input longint v);
        if (v >= 0)
            return (v + HALF_UNIT) >>> FRAC_BITS;
        else
            return -((-v + HALF_UNIT) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [OUT_POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_MAX)
            v = POS_MAX;
        else if (v < POS_MIN)
            v = POS_MIN;
        return v[OUT_POS_W-1:0];
    endfunction

    function automatic logic [OUT_SIZE_W-1:0] clamp_size(input longint v);
        if (v < 0)
            v = 0;
        else if (v > POS_MAX)
            v = POS_MAX;
        return v[OUT_SIZE_W-1:0];
    endfunction

    // Bounding box of the rectangle's image under the matrix. Products are
    // exact in 64 bits: 32-bit coefficient times 17-bit coordinate.
    function automatic box_t bound_rect(input matrix_t m, input rect_t r);
        longint x0, y0, x1, y1, px, py;
        longint nx, ny, xmin, xmax, ymin, ymax;
        longint bx, by, bw, bh;
        box_t   b;
        x0 = longint'(r.left);
        y0 = longint'(r.top);
        x1 = x0 + longint'(r.width);
        y1 = y0 + longint'(r.height);
        if (m.shear_xy == 0 && m.shear_yx == 0)
        begin
            // Axis aligned: scale origin and size apart, then flip a
            // negative size back over the origin.
            bx = round_nearest(longint'(m.scale_xx) * x0 + longint'(m.offset_x));
            by = round_nearest(longint'(m.scale_yy) * y0 + longint'(m.offset_y));
            bw = round_nearest(longint'(m.scale_xx) * longint'(r.width));
            bh = round_nearest(longint'(m.scale_yy) * longint'(r.height));
            if (bw < 0)
            begin
                bw = -bw;
                bx = bx - bw;
            end
            if (bh < 0)
            begin
                bh = -bh;
                by = by - bh;
            end
        end
        else
        begin
            // Walk the corners in order: (x0,y0) (x1,y0) (x1,y1) (x0,y1).
            for (int i = 0; i < 4; i++)
            begin
                px = (i == 1 || i == 2) ? x1 : x0;
                py = (i >= 2) ? y1 : y0;
                nx = longint'(m.scale_xx) * px + longint'(m.shear_yx) * py
                     + longint'(m.offset_x);
                ny = longint'(m.shear_xy) * px + longint'(m.scale_yy) * py
                     + longint'(m.offset_y);
                if (i == 0 || nx < xmin) xmin = nx;
                if (i == 0 || nx > xmax) xmax = nx;
                if (i == 0 || ny < ymin) ymin = ny;
                if (i == 0 || ny > ymax) ymax = ny;
            end
            bx = round_nearest(xmin);
            by = round_nearest(ymin);
            bw = round_nearest(xmax) - bx;
            bh = round_nearest(ymax) - by;
        end
        b.left   = clamp_pos(bx);
        b.top    = clamp_pos(by);
        b.width  = clamp_size(bw);
        b.height = clamp_size(bh);
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: the receiver cannot stall, so take every done cycle
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("box %0d %s got %0d expected %0d",
                                      boxes_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_boxes.size() == 0)
            begin
                report_mismatch($sformatf("box with no rect pending (left %0d top %0d)",
                                          box_left, box_top));
            end
            else
            begin
                want_box = pending_boxes.pop_front();
                check_field("left",   longint'(box_left),   longint'(want_box.left));
                check_field("top",    longint'(box_top),    longint'(want_box.top));
                check_field("width",  longint'(box_width),  longint'(want_box.width));
                check_field("height", longint'(box_height), longint'(want_box.height));
            end
            boxes_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one rect, hold it until the block takes the beat, then record
    // the box it owes. Leave start high unless the sender idles, so that
    // back-to-back beats go out every cycle.
    task automatic send_rect(input logic signed [LEFT_W-1:0] l,
                             input logic signed [LEFT_W-1:0] t,
                             input logic [SIZE_W-1:0] w,
                             input logic [SIZE_W-1:0] h);
        rect_t r;
        r = '{left: l, top: t, width: w, height: h};
        start       <= 1'b1;
        rect_left   <= l;
        rect_top    <= t;
        rect_width  <= w;
        rect_height <= h;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_boxes.push_back(bound_rect(cur_matrix, r));
        rects_sent++;
        if (cur_matrix.shear_xy == 0 && cur_matrix.shear_yx == 0)
            axis_rects++;
        else
            sheared_rects++;
        if (gaps_on && $urandom_range(0, 99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Drop start and wait until every owed box has come back. Each rect
    // yields exactly one box, so an empty queue means an empty pipe.
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
    endtask

    // Write all six registers back to back, then poke the two spare indexes
    // with junk; those writes must not land anywhere.
    task automatic load_matrix(input matrix_t m);
        logic [CFG_IDX_W-1:0] slot [8];
        logic [CFG_W-1:0]     data [8];
        drain_pipe();
        slot = '{REG_SCALE_XX, REG_SHEAR_XY, REG_SHEAR_YX, REG_SCALE_YY,
                 REG_OFFSET_X, REG_OFFSET_Y, REG_SPARE_6, REG_SPARE_7};
        data = '{m.scale_xx, m.shear_xy, m.shear_yx, m.scale_yy,
                 m.offset_x, m.offset_y, $urandom, $urandom};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= slot[i];
            cfg_data  <= data[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_matrix = m;
        matrix_loads++;
    endtask

    function automatic matrix_t make_matrix(input logic signed [CFG_W-1:0] sxx,
                                            input logic signed [CFG_W-1:0] hxy,
                                            input logic signed [CFG_W-1:0] hyx,
                                            input logic signed [CFG_W-1:0] syy,
                                            input logic signed [CFG_W-1:0] ox,
                                            input logic signed [CFG_W-1:0] oy);
        return '{scale_xx: sxx, shear_xy: hxy, shear_yx: hyx,
                 scale_yy: syy, offset_x: ox, offset_y: oy};
    endfunction

    // Coefficient mix: raw bits, small values, exact halves (ties), the
    // extremes, and values one LSB around zero.
    function automatic logic signed [CFG_W-1:0] rand_coef();
        logic signed [CFG_W-1:0] c;
        case ($urandom_range(0, 5))
            0: c = $urandom;
            1: c = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: c = (int'($urandom_range(0, 16)) - 8) * 32'sh0000_8000;
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       c = 32'sh7FFF_FFFF;
                    1:       c = 32'h8000_0000;
                    2:       c = 32'sh0001_0000;
                    3:       c = -32'sh0001_0000;
                    default: c = '0;
                endcase
            end
            4: c = int'($urandom_range(0, 2)) - 1;
            default: c = int'($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
        endcase
        return c;
    endfunction

    // About four in ten settings keep both shears at zero (fast path);
    // the rest often leave one shear at zero.
    function automatic matrix_t rand_matrix();
        matrix_t m;
        m.scale_xx = rand_coef();
        m.scale_yy = rand_coef();
        m.offset_x = rand_coef();
        m.offset_y = rand_coef();
        m.shear_xy = '0;
        m.shear_yx = '0;
        if ($urandom_range(0, 99) >= 40)
        begin
            case ($urandom_range(0, 4))
                0:       m.shear_xy = rand_coef();
                1:       m.shear_yx = rand_coef();
                default:
                begin
                    m.shear_xy = rand_coef();
                    m.shear_yx = rand_coef();
                end
            endcase
        end
        return m;
    endfunction

    task automatic send_random_rect();
        rect_t r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                r.left   = LEFT_W'($urandom);
                r.top    = LEFT_W'($urandom);
                r.width  = SIZE_W'($urandom);
                r.height = SIZE_W'($urandom);
            end
            5, 6, 7:
            begin
                r.left   = LEFT_W'(int'($urandom_range(0, 127)) - 64);
                r.top    = LEFT_W'(int'($urandom_range(0, 127)) - 64);
                r.width  = SIZE_W'($urandom_range(0, 32));
                r.height = SIZE_W'($urandom_range(0, 32));
            end
            8:
            begin
                r.left   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                r.top    = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                r.width  = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
                r.height = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
            end
            default:
            begin
                r.left   = LEFT_W'($urandom);
                r.top    = LEFT_W'($urandom);
                r.width  = '0;
                r.height = SIZE_W'($urandom_range(0, 3));
            end
        endcase
        send_rect(r.left, r.top, r.width, r.height);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Identity from reset: edge values pass straight through.
    task automatic test_reset_matrix();
        send_rect(16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF);
        send_rect(16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
        send_rect(16'sh0000, 16'sh0000, 15'h0000, 15'h0000);
        send_rect(-16'sd1, 16'sd1, 15'd1, 15'd0);
    endtask

    // Fast path: negative x scale flips the width back over the origin;
    // half-unit scales and offsets land on ties of both signs.
    task automatic test_axis_flip_and_ties();
        load_matrix(make_matrix(32'hFFFE_8000, '0, '0, 32'sh0000_8000,
                                32'sh0000_8000, 32'hFFFF_8000));
        send_rect(16'sd3, -16'sd3, 15'd3, 15'd5);
        send_rect(16'sh8000, 16'sh7FFF, 15'h7FFF, 15'd1);
        send_rect(16'sd1, 16'sd1, 15'd0, 15'd0);
    endtask

    // General path: both shears set, then only one, so the corner walk is
    // taken even with a zero term.
    task automatic test_sheared_corners();
        load_matrix(make_matrix(32'sh0001_0000, 32'sh0000_8000, -32'sh0000_4000,
                                32'sh0001_0000, 32'sh0001_2345, 32'hFFFF_8000));
        send_rect(16'sd0, 16'sd0, 15'd10, 15'd10);
        send_rect(16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF);
        send_rect(16'sh7FFF, -16'sd5, 15'd0, 15'd7);
        send_rect(16'sd5, 16'sd5, 15'd0, 15'd0);
        load_matrix(make_matrix(32'sh0001_0000, 32'sh0001_0000, '0,
                                32'sh0001_0000, '0, '0));
        send_rect(-16'sd7, 16'sd2, 15'd9, 15'd4);
        send_rect(16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF);
    endtask

    // Extreme coefficients and offsets drive the outputs to extreme values; the left edge hits its clamp.
    task automatic test_saturation();
        load_matrix(make_matrix(32'sh7FFF_FFFF, '0, '0, 32'h8000_0000,
                                32'sh7FFF_FFFF, 32'h8000_0000));
        send_rect(16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF);
        send_rect(16'sh8000, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
        send_rect(16'sd0, 16'sd0, 15'h7FFF, 15'h0000);
        load_matrix(make_matrix(32'h8000_0000, 32'sh7FFF_FFFF, 32'h8000_0000,
                                32'sh7FFF_FFFF, 32'h8000_0000, 32'sh7FFF_FFFF));
        send_rect(16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
        send_rect(16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF);
        send_rect(16'sh8000, 16'sh7FFF, 15'h0000, 15'h0000);
    endtask

    // Random matrices, each followed by a run of random rects.
    task automatic test_random_matrices(input int settings, input int rects_each);
        for (int s = 0; s < settings; s++)
        begin
            load_matrix(rand_matrix());
            repeat (rects_each) send_random_rect();
        end
    endtask

    // One long stretch at full rate with the sender never idling.
    task automatic test_full_rate_burst(input int count);
        load_matrix(rand_matrix());
        gaps_on = 1'b0;
        repeat (count) send_random_rect();
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cur_matrix = make_matrix(32'sh0001_0000, '0, '0, 32'sh0001_0000, '0, '0);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_axis_flip_and_ties();
        test_sheared_corners();
        test_saturation();
        test_random_matrices(11, 60);
        test_full_rate_burst(300);
        test_random_matrices(11, 60);

        // Hold off the verdict until the pipe is empty, then watch a few
        // more cycles for stray results.
        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d rects under %0d matrix loads: %0d axis-aligned, %0d sheared",
                 rects_sent, matrix_loads, axis_rects, sheared_rects);
        $display("checked %0d boxes, %0d mismatches", boxes_checked, errors);
        if (errors == 0)
            $display("affine_rect_bounding_box_top_tb: PASS");
        else
            $display("affine_rect_bounding_box_top_tb: FAIL");
        $finish;
    end

endmodule
